[hdl/tdrg_pkg.sv]
// Package for the distance row generator: field widths, ops, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package tdrg_pkg;
  localparam int CoordW = 24;
  localparam int DistW  = 17;
  localparam int IdxW   = 6;
  localparam int CntW   = 7;
  localparam int SumW   = 50;
  localparam int RootW  = 25;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [IdxW-1:0]      node_index;
    logic [CoordW-1:0]    coord_x;
    logic [CoordW-1:0]    coord_y;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0]  row_node;
    logic [IdxW-1:0]  column_node;
    logic [DistW-1:0] distance;
    logic             last;
    logic             index_error;
  } res_t;
endpackage

[hdl/tsp_distance_row_generator_core.sv]
// Top level of the distance row generator: front end, config registers.
// Depends on tdrg_pkg, tdrg_cmd_fifo, tdrg_engine.
//
// Input channel (in_*): op 0 stores node coordinates, op 1 asks for a row.
// Result channel (out_*): one transfer per column 0..count-1, last on the
// final one; a row at or beyond node_count gives a single index_error result.
// A two-entry queue separates intake from the row engine, so a store or row
// request is taken while results still drain.
// A row of N nodes issues one column per cycle, unless out_stall holds the
// pipeline, into a pipelined distance unit (store read, subtract, square,
// divide by 10 in mode 1, square root one bit per stage, rounding); the
// square root pipeline sets the latency, the column sequencer the throughput.
// A row request waits for the previous row's pipeline to drain.
// out_stall freezes the whole pipeline; nothing is lost.
// Reset clears control and sets distance_mode 0, node_count 64; the
// coordinate store is undefined until written.
`timescale 1ns / 1ps
module tsp_distance_row_generator_core import tdrg_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [IdxW-1:0]          in_node_index,
  input  logic signed [CoordW-1:0] in_coord_x,
  input  logic signed [CoordW-1:0] in_coord_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IdxW-1:0]          out_row_node,
  output logic [IdxW-1:0]          out_column_node,
  output logic [DistW-1:0]         out_distance,
  output logic                     out_last,
  output logic                     out_index_error,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic            mode_r;
  logic [CntW-1:0] count_r;
  cmd_t            in_cmd, q_cmd;
  logic            q_valid, q_take;
  res_t            res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; count_r <= CntW'(64);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_MODE) begin
      mode_r <= pwdata[0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_COUNT) begin
      count_r <= pwdata[CntW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MODE) prdata[0] = mode_r;
    else prdata[CntW-1:0] = count_r;
  end

  assign in_cmd = '{op: in_op, node_index: in_node_index,
                    coord_x: in_coord_x, coord_y: in_coord_y};

  tdrg_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_valid), .wr_stall(in_stall),
    .wr_data(in_cmd), .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_cmd)
  );

  tdrg_engine #(.MAX_NODES(MAX_NODES)) u_eng (
    .clk(clk), .rst_n(rst_n), .mode(mode_r), .count(count_r),
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_row_node    = res.row_node;
  assign out_column_node = res.column_node;
  assign out_distance    = res.distance;
  assign out_last        = res.last;
  assign out_index_error = res.index_error;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_last && out_distance == '0)
    else $error("index error result not final");
  a_err_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_column_node == '0)
    else $error("index error result has column");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance))
    else $error("stalled result changed");
endmodule

[hdl/tdrg_cmd_fifo.sv]
// Short command queue between the front end and the row engine.
// Depends on tdrg_pkg.
`timescale 1ns / 1ps
module tdrg_cmd_fifo import tdrg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_take,
  output cmd_t rd_data
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_stall = cnt_r[1];
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

[hdl/tdrg_isqrt.sv]
// Pipelined integer square root, floor, one result bit per stage.
// Carries a tag through the stages. Depends on tdrg_pkg.
`timescale 1ns / 1ps
module tdrg_isqrt import tdrg_pkg::*; #(
  parameter int TagW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SumW-1:0]   in_val,
  input  logic [TagW-1:0]   in_tag,
  output logic              out_valid,
  output logic [RootW-1:0]  out_root,
  output logic [SumW-1:0]   out_val,
  output logic [TagW-1:0]   out_tag
);
  logic [SumW-1:0]  val_r  [RootW+1];
  logic [SumW:0]    rem_r  [RootW+1];
  logic [RootW-1:0] root_r [RootW+1];
  logic [TagW-1:0]  tag_r  [RootW+1];
  logic             vld_r  [RootW+1];

  always_comb begin
    val_r[0]  = in_val;
    rem_r[0]  = '0;
    root_r[0] = '0;
    tag_r[0]  = in_tag;
    vld_r[0]  = in_valid;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [SumW:0]    rem_sh, trial;
    logic [RootW-1:0] rt_nxt;
    logic [SumW:0]    rm_nxt;
    always_comb begin
      rem_sh = {rem_r[s][SumW-2:0], val_r[s][SumW-1-2*s -: 2]};
      trial  = {{(SumW-RootW-1){1'b0}}, root_r[s], 2'b01};
      if (rem_sh >= trial) begin
        rm_nxt = rem_sh - trial;
        rt_nxt = {root_r[s][RootW-2:0], 1'b1};
      end else begin
        rm_nxt = rem_sh;
        rt_nxt = {root_r[s][RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[s+1]  <= val_r[s];
        rem_r[s+1]  <= rm_nxt;
        root_r[s+1] <= rt_nxt;
        tag_r[s+1]  <= tag_r[s];
      end
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else if (en) vld_r[s+1] <= vld_r[s];
    end
  end

  assign out_valid = vld_r[RootW];
  assign out_root  = root_r[RootW];
  assign out_val   = val_r[RootW];
  assign out_tag   = tag_r[RootW];
endmodule

[hdl/tdrg_engine.sv]
// Row engine: node store, column sequencer and the pipelined distance unit.
// Depends on tdrg_pkg, tdrg_isqrt and tdrg_div10.
`timescale 1ns / 1ps
module tdrg_engine import tdrg_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mode,
  input  logic [CntW-1:0] count,
  input  logic            cmd_valid,
  output logic            cmd_take,
  input  cmd_t            cmd,
  output logic            out_valid,
  input  logic            out_stall,
  output res_t            out_res
);
  localparam int AW = $clog2(MAX_NODES);
  localparam int TagW = 2 * IdxW + 3;

  logic signed [CoordW-1:0] sx_r [MAX_NODES];
  logic signed [CoordW-1:0] sy_r [MAX_NODES];

  // sequencer
  logic            busy_r;
  logic [IdxW-1:0] row_r;
  logic [CntW-1:0] col_r, cnt_r;
  logic            stall;
  logic [CntW-1:0] eff_cnt;
  logic            bad;

  // pipeline control: all stages advance together when not stalled
  logic en;
  logic [7:0] inflight_r;
  localparam int Depth = RootW + 8;

  assign eff_cnt = (count > CntW'(MAX_NODES)) ? CntW'(MAX_NODES) : count;
  assign bad     = {1'b0, cmd.node_index} >= eff_cnt;

  // stage A: issue; stage B: read store; stage C: diffs; stage D: squares;
  // stage E: divide by 10
  logic            a_v, a_err, a_last;
  logic [IdxW-1:0] a_row, a_col;
  logic            b_v, b_err, b_last;
  logic [IdxW-1:0] b_row, b_col;
  logic signed [CoordW-1:0] b_x1, b_y1, b_x2, b_y2;
  logic            c_v, c_err, c_last;
  logic [IdxW-1:0] c_row, c_col;
  logic signed [CoordW:0] c_dx, c_dy;
  logic [CoordW-1:0] c_ax, c_ay;
  logic [2*CoordW-1:0] sq_x, sq_y;
  logic            d_v;
  logic [TagW-1:0] d_tag;
  logic [SumW-1:0] d_s;
  logic            e_v;
  logic [TagW-1:0] e_tag;
  logic [SumW-1:0] e_s;
  logic [SumW-1:0] sq_in;
  logic            q_v;
  logic [TagW-1:0] q_tag;
  logic [SumW-1:0] q_s;
  logic            r_v;
  logic [RootW-1:0] r_root;
  logic [SumW-1:0] r_val;
  logic [TagW-1:0] r_tag;
  logic            o_v_r;
  res_t            o_r;

  assign stall    = o_v_r && out_stall;
  assign en       = !stall;
  assign cmd_take = en && !busy_r && cmd_valid &&
                    (cmd.op == OP_STORE || inflight_r == 8'd0);

  // magnitudes of the differences; they fit in CoordW bits
  assign c_ax = c_dx[CoordW] ? CoordW'(-c_dx) : c_dx[CoordW-1:0];
  assign c_ay = c_dy[CoordW] ? CoordW'(-c_dy) : c_dy[CoordW-1:0];
  assign sq_x = c_ax * c_ax;
  assign sq_y = c_ay * c_ay;

  always_comb begin
    a_v = 1'b0; a_err = 1'b0; a_last = 1'b0; a_row = row_r; a_col = col_r[IdxW-1:0];
    if (busy_r) begin
      a_v = 1'b1; a_last = (col_r + 1'b1) == cnt_r;
    end else if (cmd_take && cmd.op == OP_ROW && bad) begin
      a_v = 1'b1; a_err = 1'b1; a_last = 1'b1; a_row = cmd.node_index; a_col = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.op == OP_STORE && {1'b0, cmd.node_index} < CntW'(MAX_NODES)) begin
      sx_r[cmd.node_index[AW-1:0]] <= cmd.coord_x;
      sy_r[cmd.node_index[AW-1:0]] <= cmd.coord_y;
    end
    if (en) begin
      b_row <= a_row; b_col <= a_col; b_err <= a_err; b_last <= a_last;
      b_x1 <= sx_r[a_row[AW-1:0]]; b_y1 <= sy_r[a_row[AW-1:0]];
      b_x2 <= sx_r[a_col[AW-1:0]]; b_y2 <= sy_r[a_col[AW-1:0]];
      c_row <= b_row; c_col <= b_col; c_err <= b_err; c_last <= b_last;
      c_dx <= (CoordW+1)'(b_x1) - (CoordW+1)'(b_x2);
      c_dy <= (CoordW+1)'(b_y1) - (CoordW+1)'(b_y2);
      d_tag <= {c_row, c_col, c_err, c_last, mode};
      d_s <= SumW'(sq_x) + SumW'(sq_y);
      e_tag <= d_tag;
      e_s <= d_s;
      q_tag <= e_tag;
      // ceil(S/10) for ATT from tdrg_div10, which splits S+9 into hi/lo parts
      q_s <= e_tag[0] ? sq_in : e_s;
    end
    if (!rst_n) begin
      busy_r <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0; e_v <= 1'b0; q_v <= 1'b0;
      inflight_r <= 8'd0;
    end else begin
      if (en) begin
        b_v <= a_v; c_v <= b_v; d_v <= c_v; e_v <= d_v; q_v <= e_v;
        if (busy_r) begin
          col_r <= col_r + 1'b1;
          if (a_last) busy_r <= 1'b0;
        end else if (cmd_take && cmd.op == OP_ROW && !bad) begin
          busy_r <= 1'b1; row_r <= cmd.node_index; col_r <= '0; cnt_r <= eff_cnt;
        end
      end
      if (en) inflight_r <= inflight_r + {7'd0, a_v} - {7'd0, r_v};
    end
  end

  // divide by 10 rounding up: S < 2^50, q = floor((S+9)/10) split as hi/lo digits
  tdrg_div10 u_div (.clk(clk), .en(en), .s(d_s), .q(sq_in));

  tdrg_isqrt #(.TagW(TagW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_v), .in_val(q_s),
    .in_tag(q_tag), .out_valid(r_v), .out_root(r_root), .out_val(r_val),
    .out_tag(r_tag)
  );

  logic [RootW+1:0] c_up, d_fin;
  always_comb begin
    c_up = {2'b00, r_root} + {{(RootW+1){1'b0}},
           ({r_root, r_root} != 0 && (r_root * r_root) != r_val)};
    if (r_tag[0]) d_fin = (c_up + (RootW+2)'(255)) >> 8;
    else          d_fin = ({2'b00, r_root} + (RootW+2)'(128)) >> 8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r.row_node    <= r_tag[TagW-1 -: IdxW];
      o_r.column_node <= r_tag[TagW-1-IdxW -: IdxW];
      o_r.index_error <= r_tag[2];
      o_r.last        <= r_tag[1];
      o_r.distance    <= r_tag[2] ? '0 : d_fin[DistW-1:0];
    end
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= r_v;
  end

  assign out_valid = o_v_r;
  assign out_res   = o_r;
  logic unused;
  assign unused = c_v ^ d_v ^ (Depth == 0);
endmodule

[hdl/tdrg_div10.sv]
// Exact ceil(s/10) over one registered stage placed after the square stage.
// Depends on tdrg_pkg.
`timescale 1ns / 1ps
module tdrg_div10 import tdrg_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SumW-1:0] s,
  output logic [SumW-1:0] q
);
  // split t = s+9 = h*2^25 + l; t/10 = h*3355443 + (h*2 + l)/10 (2^25 = 10*3355443+2)
  logic [SumW:0]  t;
  logic [25:0]    h;
  logic [24:0]    l;
  logic [SumW:0]  ph;
  logic [31:0]    rest;
  logic [SumW:0]  ph_r;
  logic [31:0]    rest_r;
  logic [31:0]    rq;
  logic [63:0]    rm;
  always_comb begin
    t    = {1'b0, s} + (SumW+1)'(9);
    h    = t[SumW:25];
    l    = t[24:0];
    ph   = h * 26'd3355443;
    rest = 32'(h) * 32'd2 + 32'(l);
  end

  // hold the split between the two multiplies
  always_ff @(posedge clk) begin
    if (en) begin
      ph_r   <= ph;
      rest_r <= rest;
    end
  end

  always_comb begin
    rm = 64'(rest_r) * 64'd3435973837;
    rq = 32'(rm >> 35);
    q  = SumW'(ph_r + (SumW+1)'(rq));
  end
endmodule
